// ===== rtl/mqtt_packet_deframer_assert.svh =====
// assertion macros for the checker file
`ifndef MQTT_PACKET_DEFRAMER_ASSERT_SVH
`define MQTT_PACKET_DEFRAMER_ASSERT_SVH

// checked only outside reset
`define MPD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define MPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mpd_pkg.sv =====
// types and constants of the mqtt packet deframer
package mpd_pkg;

  localparam int MAX_LENGTH_BYTES = 4;
  localparam int LEN_W            = 28;
  localparam int CNT_W            = 3;
  localparam int FIFO_DEPTH       = 8;
  localparam int PTR_W            = $clog2(FIFO_DEPTH);
  localparam int FILL_W           = PTR_W + 1;
  // room needed before a byte is taken: two results in flight plus two for the new byte
  localparam int READY_LIMIT      = FIFO_DEPTH - 4;
  localparam int TDATA_W          = 48;
  localparam int TUSER_W          = 2;

  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam logic [3:0] TYPE_SUBACK  = 4'd9;

  localparam logic [1:0] KIND_TOPIC   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_MALFORMED = 1'b1;

  // tdata field positions
  localparam int TD_RETAIN = 16;
  localparam int TD_STATUS = 41;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  data_value;
    logic [3:0]  packet_kind;
    logic [3:0]  header_flags;
    logic        retain_flag;
    logic [7:0]  reply_code;
    logic [15:0] ident;
    logic        status;
    logic        last;
  } res_t;

  // up to two results per received byte; slot1 is used only with slot0
  typedef struct packed {
    logic valid0;
    logic valid1;
    res_t slot0;
    res_t slot1;
  } par_out_t;

endpackage

// ===== rtl/mqtt_packet_deframer.sv =====
// mqtt 3.1.1 packet deframer top level
// Takes the broker byte stream one byte per transfer and splits it into MQTT 3.1.1
// control packets. PUBLISH topic bytes and payload bytes come out one per transfer
// (tuser 0 and 1); every packet closes with a summary transfer (tuser 2, tlast high)
// that carries the header nibbles, the retain bit, the CONNACK/SUBACK return code,
// the SUBACK packet id and an ok/malformed status. A continuation bit on the fourth
// length byte gives a malformed summary and the block then drops all input until
// reset. A byte is registered at the input, parsed in the next cycle and its zero,
// one or two results are written into an eight-entry result queue, so one byte per
// cycle goes through in steady state with the output ready. The only stall comes
// from the queue: the input holds off while more than four results are queued.
module mqtt_packet_deframer
  import mpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // data_value[7:0], packet_kind[11:8], header_flags[15:12], retain_flag[16],
  // reply_code[24:17], ident[40:25], status[41], zero fill[47:42]
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [TUSER_W-1:0] m_axis_tuser,   // item_kind
  output logic               m_axis_tlast    // last
);

  logic              in_valid;
  logic [7:0]        in_byte;
  par_out_t          par_res;
  res_t              head;
  logic [FILL_W-1:0] fill;

  // accept while the queue can hold the worst case of the byte in flight and this one
  assign s_axis_tready = (fill <= FILL_W'(READY_LIMIT));

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  mpd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .res      (par_res)
  );

  mpd_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (par_res),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (head),
    .fill     (fill)
  );

  // pack the head result onto the master side
  assign m_axis_tdata = {6'd0, head.status, head.ident, head.reply_code, head.retain_flag,
                         head.header_flags, head.packet_kind, head.data_value};
  assign m_axis_tuser = head.item_kind;
  assign m_axis_tlast = head.last;

endmodule

// ===== rtl/mpd_parser.sv =====
// packet parser: state registers and per-byte next-state logic
module mpd_parser
  import mpd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output par_out_t       res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY,
    PH_SKIP,
    PH_HALT
  } phase_t;

  phase_t            phase, phase_next;
  logic [3:0]        kind_reg, kind_reg_next;
  logic [3:0]        flags_reg, flags_reg_next;
  logic [LEN_W-1:0]  length_acc, length_acc_next;
  logic [CNT_W-1:0]  length_byte_count, length_byte_count_next;
  logic [LEN_W-1:0]  body_count, body_count_next;
  logic [15:0]       topic_length, topic_length_next;
  logic [7:0]        code_reg, code_reg_next;
  logic [15:0]       ident_reg, ident_reg_next;

  logic [LEN_W-1:0]  len_new, bc_inc, topic_end, payload_start, need_pub;
  logic [LEN_W-1:0]  need_min;
  logic [1:0]        id_skip;
  logic [CNT_W-1:0]  cnt_inc;
  logic              body_end;
  res_t              data_item, summary_ok, summary_bad;

  always_comb begin
    // length group placed by its position, seven bits each
    case (length_byte_count[1:0])
      2'd0:    len_new = length_acc | {21'd0, in_byte[6:0]};
      2'd1:    len_new = length_acc | {14'd0, in_byte[6:0], 7'd0};
      2'd2:    len_new = length_acc | {7'd0, in_byte[6:0], 14'd0};
      default: len_new = length_acc | {in_byte[6:0], 21'd0};
    endcase
    cnt_inc  = length_byte_count + CNT_W'(1);
    need_min = (kind_reg == TYPE_CONNACK || kind_reg == TYPE_PUBLISH) ? LEN_W'(2) :
               (kind_reg == TYPE_SUBACK) ? LEN_W'(3) : '0;
    bc_inc   = body_count + LEN_W'(1);
    body_end = (bc_inc >= length_acc);
    id_skip  = (flags_reg[2:1] != 2'b00) ? 2'd2 : 2'd0;
    topic_end     = LEN_W'(topic_length) + LEN_W'(2);
    payload_start = topic_end + LEN_W'(id_skip);
    need_pub      = LEN_W'({topic_length[15:8], in_byte}) + LEN_W'(2) + LEN_W'(id_skip);
  end

  always_comb begin
    phase_next             = phase;
    kind_reg_next          = kind_reg;
    flags_reg_next         = flags_reg;
    length_acc_next        = length_acc;
    length_byte_count_next = length_byte_count;
    body_count_next        = body_count;
    topic_length_next      = topic_length;
    code_reg_next          = code_reg;
    ident_reg_next         = ident_reg;
    res.valid0             = 1'b0;
    res.valid1             = 1'b0;

    data_item              = '0;
    data_item.data_value   = in_byte;
    data_item.packet_kind  = kind_reg;
    data_item.header_flags = flags_reg;

    summary_bad              = '0;
    summary_bad.item_kind    = KIND_SUMMARY;
    summary_bad.packet_kind  = kind_reg;
    summary_bad.header_flags = flags_reg;
    summary_bad.status       = STATUS_MALFORMED;
    summary_bad.last         = 1'b1;

    if (in_valid) begin
      case (phase)
        PH_HEADER: begin
          kind_reg_next          = in_byte[7:4];
          flags_reg_next         = in_byte[3:0];
          length_acc_next        = '0;
          length_byte_count_next = '0;
          body_count_next        = '0;
          topic_length_next      = '0;
          code_reg_next          = '0;
          ident_reg_next         = '0;
          phase_next             = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_acc_next        = len_new;
          length_byte_count_next = cnt_inc;
          body_count_next        = '0;
          if (in_byte[7]) begin
            if (cnt_inc >= CNT_W'(MAX_LENGTH_BYTES)) begin
              res.valid0 = 1'b1;
              phase_next = PH_HALT;
            end
          end else if (len_new < need_min) begin
            res.valid0 = 1'b1;
            phase_next = (len_new == '0) ? PH_HEADER : PH_SKIP;
          end else if (len_new == '0) begin
            res.valid0 = 1'b1;
            phase_next = PH_HEADER;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_SKIP: begin
          body_count_next = bc_inc;
          if (body_end) begin
            phase_next = PH_HEADER;
          end
        end
        PH_BODY: begin
          body_count_next = bc_inc;
          if (kind_reg == TYPE_CONNACK) begin
            if (body_count == LEN_W'(1)) begin
              code_reg_next = in_byte;
            end
          end else if (kind_reg == TYPE_SUBACK) begin
            if (body_count == LEN_W'(0)) begin
              ident_reg_next = {in_byte, 8'd0};
            end else if (body_count == LEN_W'(1)) begin
              ident_reg_next = {ident_reg[15:8], in_byte};
            end else if (body_count == LEN_W'(2)) begin
              code_reg_next = in_byte;
            end
          end else if (kind_reg == TYPE_PUBLISH) begin
            if (body_count == LEN_W'(0)) begin
              topic_length_next = {in_byte, 8'd0};
            end else if (body_count == LEN_W'(1)) begin
              topic_length_next = {topic_length[15:8], in_byte};
            end else if (body_count < topic_end) begin
              data_item.item_kind = KIND_TOPIC;
              res.valid0          = 1'b1;
            end else if (body_count >= payload_start) begin
              data_item.item_kind = KIND_PAYLOAD;
              res.valid0          = 1'b1;
            end
          end
          if (kind_reg == TYPE_PUBLISH && body_count == LEN_W'(1) &&
              need_pub > length_acc) begin
            // topic does not fit the body: report and drop the rest
            res.valid0 = 1'b1;
            phase_next = body_end ? PH_HEADER : PH_SKIP;
          end else if (body_end) begin
            if (res.valid0) begin
              res.valid1 = 1'b1;
            end else begin
              res.valid0 = 1'b1;
            end
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase
    end

    summary_ok              = '0;
    summary_ok.item_kind    = KIND_SUMMARY;
    summary_ok.packet_kind  = kind_reg;
    summary_ok.header_flags = flags_reg;
    summary_ok.retain_flag  = (kind_reg == TYPE_PUBLISH) ? flags_reg[0] : 1'b0;
    summary_ok.reply_code   = (kind_reg == TYPE_CONNACK || kind_reg == TYPE_SUBACK) ?
                              code_reg_next : 8'd0;
    summary_ok.ident        = (kind_reg == TYPE_SUBACK) ? ident_reg_next : 16'd0;
    summary_ok.status       = STATUS_OK;
    summary_ok.last         = 1'b1;

    // pick slot contents from where the item came from
    if (phase == PH_LENGTH) begin
      res.slot0 = (in_byte[7] || len_new < need_min) ? summary_bad : summary_ok;
    end else if (kind_reg == TYPE_PUBLISH && body_count == LEN_W'(1) &&
                 need_pub > length_acc) begin
      res.slot0 = summary_bad;
    end else if (res.valid1 || data_item.item_kind == KIND_TOPIC ||
                 data_item.item_kind == KIND_PAYLOAD) begin
      res.slot0 = (res.valid1 || !body_end) ? data_item : summary_ok;
    end else begin
      res.slot0 = summary_ok;
    end
    res.slot1 = summary_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      kind_reg          <= '0;
      flags_reg         <= '0;
      length_acc        <= '0;
      length_byte_count <= '0;
      body_count        <= '0;
      topic_length      <= '0;
      code_reg          <= '0;
      ident_reg         <= '0;
    end else begin
      phase             <= phase_next;
      kind_reg          <= kind_reg_next;
      flags_reg         <= flags_reg_next;
      length_acc        <= length_acc_next;
      length_byte_count <= length_byte_count_next;
      body_count        <= body_count_next;
      topic_length      <= topic_length_next;
      code_reg          <= code_reg_next;
      ident_reg         <= ident_reg_next;
    end
  end

endmodule

// ===== rtl/mpd_out_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one
module mpd_out_fifo
  import mpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  par_out_t          wr,
  output logic              rd_valid,
  input  logic              rd_ready,
  output res_t              rd_data,
  output logic [FILL_W-1:0] fill
);

  res_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wp, rp;
  logic [FILL_W-1:0] pushes;
  logic              pop;

  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rp];
  assign pop      = rd_valid && rd_ready;
  assign pushes   = FILL_W'(wr.valid0) + FILL_W'(wr.valid1);

  always_ff @(posedge clk) begin
    if (wr.valid0) begin
      mem[wp] <= wr.slot0;
    end
    if (wr.valid1) begin
      mem[wp + PTR_W'(1)] <= wr.slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      wp   <= wp + PTR_W'(pushes);
      rp   <= rp + PTR_W'(pop);
      fill <= fill + pushes - FILL_W'(pop);
    end
  end

endmodule

// ===== rtl/mpd_checker.sv =====
// port-level checker for the deframer and its bind
`include "mqtt_packet_deframer_assert.svh"

module mpd_checker
  import mpd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [7:0]         s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [TUSER_W-1:0] m_axis_tuser,
  input logic               m_axis_tlast
);

  // a pending byte stays on the bus until it is taken
  property p_in_hold;
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata);
  endproperty

  property p_out_hold;
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast);
  endproperty

  property p_last_on_summary;
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_SUMMARY));
  endproperty

  property p_data_clean;
    m_axis_tvalid && (m_axis_tuser != KIND_SUMMARY) |->
      (m_axis_tdata[TD_STATUS:TD_RETAIN] == '0);
  endproperty

  `MPD_ASSERT(a_in_hold, clk, rst, p_in_hold, "pending byte changed before its transfer")
  `MPD_ASSERT(a_out_hold, clk, rst, p_out_hold, "stalled result changed")
  `MPD_ASSERT(a_last_on_summary, clk, rst, p_last_on_summary, "tlast does not match summary kind")
  `MPD_ASSERT(a_data_clean, clk, rst, p_data_clean, "data transfer carries summary fields")
  `MPD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "result offered right after reset")

endmodule

bind mqtt_packet_deframer mpd_checker u_mpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb.sv =====
// self-checking testbench for the mqtt packet deframer
module tb;
  import mpd_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = 8'h00;   // rx_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // data_value[7:0], packet_kind[11:8], header_flags[15:12], retain_flag[16],
  // reply_code[24:17], ident[40:25], status[41], zero fill[47:42]
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [TUSER_W-1:0] m_axis_tuser;           // item_kind
  logic               m_axis_tlast;           // last

  mqtt_packet_deframer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // broker stream still to be sent, and the parsed items it must produce
  logic [7:0] broker_bytes[$];
  res_t       parsed_q[$];

  int errors       = 0;
  int bytes_taken  = 0;
  int n_summaries  = 0;
  int n_malformed  = 0;
  int n_topic      = 0;
  int n_payload    = 0;

  // ---------------------------------------------------------------------------
  // parser shadow: same walk over the stream as the block, one byte at a time
  // ---------------------------------------------------------------------------
  typedef enum logic [2:0] {
    AWAIT_HEADER, READ_LENGTH, WALK_BODY, SKIP_BODY, HALTED
  } parse_phase_t;

  parse_phase_t phase_q   = AWAIT_HEADER;
  logic [3:0]   pkt_kind  = '0;
  logic [3:0]   pkt_flags = '0;
  logic [27:0]  rem_len   = '0;
  logic [2:0]   len_bytes = '0;
  logic [27:0]  body_idx  = '0;
  logic [15:0]  topic_len = '0;
  logic [7:0]   ack_code  = '0;
  logic [15:0]  ack_ident = '0;

  task automatic note_summary(input bit malformed);
    res_t r;
    r = '0;
    r.item_kind    = KIND_SUMMARY;
    r.packet_kind  = pkt_kind;
    r.header_flags = pkt_flags;
    r.last         = 1'b1;
    if (malformed) begin
      r.status = STATUS_MALFORMED;
      n_malformed++;
    end else begin
      r.status = STATUS_OK;
      if (pkt_kind == TYPE_PUBLISH) r.retain_flag = pkt_flags[0];
      if (pkt_kind == TYPE_CONNACK || pkt_kind == TYPE_SUBACK) r.reply_code = ack_code;
      if (pkt_kind == TYPE_SUBACK) r.ident = ack_ident;
    end
    parsed_q.insert(parsed_q.size(), r);
    n_summaries++;
  endtask

  task automatic note_data(input logic [1:0] kind, input logic [7:0] b);
    res_t r;
    r = '0;
    r.item_kind    = kind;
    r.data_value   = b;
    r.packet_kind  = pkt_kind;
    r.header_flags = pkt_flags;
    parsed_q.insert(parsed_q.size(), r);
    if (kind == KIND_TOPIC) n_topic++;
    else n_payload++;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int unsigned need;
    int unsigned idx;
    int unsigned id_skip;
    bit          done;
    id_skip = (pkt_flags[2:1] != 2'b00) ? 2 : 0;
    case (phase_q)
      HALTED: begin
        // overlong length seen: everything is dropped until reset
      end
      AWAIT_HEADER: begin
        pkt_kind  = b[7:4];
        pkt_flags = b[3:0];
        rem_len   = '0;
        len_bytes = '0;
        body_idx  = '0;
        topic_len = '0;
        ack_code  = '0;
        ack_ident = '0;
        phase_q   = READ_LENGTH;
      end
      READ_LENGTH: begin
        if (len_bytes < MAX_LENGTH_BYTES)
          rem_len = rem_len | (28'(b[6:0]) << (7 * len_bytes));
        len_bytes++;
        if (b[7]) begin
          // continuation on the last allowed length byte: malformed, then halt
          if (len_bytes >= MAX_LENGTH_BYTES) begin
            phase_q = HALTED;
            note_summary(1'b1);
          end
        end else begin
          if (pkt_kind == TYPE_CONNACK || pkt_kind == TYPE_PUBLISH) need = 2;
          else if (pkt_kind == TYPE_SUBACK) need = 3;
          else need = 0;
          body_idx = '0;
          if (rem_len < need) begin
            // body too short for its type: flag now, drop the body quietly
            note_summary(1'b1);
            phase_q = (rem_len == 0) ? AWAIT_HEADER : SKIP_BODY;
          end else if (rem_len == 0) begin
            note_summary(1'b0);
            phase_q = AWAIT_HEADER;
          end else begin
            phase_q = WALK_BODY;
          end
        end
      end
      SKIP_BODY: begin
        body_idx++;
        if (body_idx >= rem_len) phase_q = AWAIT_HEADER;
      end
      default: begin
        idx  = 32'(body_idx);
        body_idx++;
        done = (body_idx >= rem_len);
        case (pkt_kind)
          TYPE_CONNACK: begin
            if (idx == 1) ack_code = b;
          end
          TYPE_SUBACK: begin
            if (idx == 0) ack_ident = {b, 8'h00};
            else if (idx == 1) ack_ident[7:0] = b;
            else if (idx == 2) ack_code = b;
          end
          TYPE_PUBLISH: begin
            if (idx == 0) begin
              topic_len = {b, 8'h00};
            end else if (idx == 1) begin
              topic_len[7:0] = b;
              need = 2 + topic_len + id_skip;
              // topic plus packet id do not fit in the body
              if (need > rem_len) begin
                note_summary(1'b1);
                phase_q = done ? AWAIT_HEADER : SKIP_BODY;
                return;
              end
            end else if (idx < 2 + topic_len) begin
              note_data(KIND_TOPIC, b);
            end else if (idx >= 2 + topic_len + id_skip) begin
              note_data(KIND_PAYLOAD, b);
            end
          end
          default: begin
            // other types are walked by length only
          end
        endcase
        if (done) begin
          note_summary(1'b0);
          phase_q = AWAIT_HEADER;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata);
        void'(broker_bytes.pop_front());
        bytes_taken++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 24);
        end
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // transfer still pending: keep the byte on the bus
      end else if (gap_left > 0 || broker_bytes.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= broker_bytes[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: ready pattern switches between open, choppy and long stalls
  // ---------------------------------------------------------------------------
  int ready_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (hold_left == 0) begin
            hold_left = m_axis_tready ? $urandom_range(1, 12) : $urandom_range(1, 4);
            m_axis_tready <= ~m_axis_tready;
          end else begin
            hold_left--;
          end
        end
      endcase
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  res_t seen;
  res_t want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.item_kind    = m_axis_tuser;
      seen.data_value   = m_axis_tdata[7:0];
      seen.packet_kind  = m_axis_tdata[11:8];
      seen.header_flags = m_axis_tdata[15:12];
      seen.retain_flag  = m_axis_tdata[TD_RETAIN];
      seen.reply_code   = m_axis_tdata[24:17];
      seen.ident        = m_axis_tdata[40:25];
      seen.status       = m_axis_tdata[TD_STATUS];
      seen.last         = m_axis_tlast;
      if (parsed_q.size() == 0) begin
        $error("unexpected result transfer: tuser 0x%0h tdata 0x%0h",
               m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = parsed_q.pop_front();
        compare_field("item_kind",    32'(want.item_kind),    32'(seen.item_kind));
        compare_field("data_value",   32'(want.data_value),   32'(seen.data_value));
        compare_field("packet_kind",  32'(want.packet_kind),  32'(seen.packet_kind));
        compare_field("header_flags", 32'(want.header_flags), 32'(seen.header_flags));
        compare_field("retain_flag",  32'(want.retain_flag),  32'(seen.retain_flag));
        compare_field("reply_code",   32'(want.reply_code),   32'(seen.reply_code));
        compare_field("ident",        32'(want.ident),        32'(seen.ident));
        compare_field("status",       32'(want.status),       32'(seen.status));
        compare_field("last",         32'(want.last),         32'(seen.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stream construction, reset and end of run
  // ---------------------------------------------------------------------------
  localparam int OPENING_N = 25;
  localparam logic [7:0] OPENING [OPENING_N] = '{
    8'h20, 8'h02, 8'h01, 8'h00,               // connack, return code zero
    8'h9F, 8'h03, 8'hFF, 8'hFF, 8'h80,        // suback, all-ones id, failure code
    8'h31, 8'h05, 8'h00, 8'h01, 8'h61,        // publish qos0 retain, one topic byte
    8'hFF, 8'h00,                             // payload; last byte also closes packet
    8'hD0, 8'h00,                             // pingresp, empty body
    8'h20, 8'h00,                             // connack with no body: malformed
    8'h36, 8'h03, 8'h00, 8'h01, 8'h7A         // qos3 publish too short for topic plus id
  };

  initial begin
    logic [7:0]  body[$];
    logic [7:0]  hdr;
    logic [3:0]  flags;
    logic [3:0]  ptype;
    int unsigned sel;
    int unsigned tl;
    int unsigned pl;
    int unsigned cut;
    int unsigned blen;
    int unsigned minb;
    int unsigned nb;

    foreach (OPENING[i]) broker_bytes.insert(broker_bytes.size(), OPENING[i]);

    // random packets: mostly well-formed with random content, some broken
    while (broker_bytes.size() < 940) begin
      body.delete();
      sel   = $urandom_range(0, 99);
      flags = 4'($urandom);
      if (sel < 40) begin
        hdr = {TYPE_PUBLISH, flags};
        tl  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
        pl  = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 150) : $urandom_range(0, 8);
        body.insert(body.size(), 8'(tl >> 8));
        body.insert(body.size(), 8'(tl));
        repeat (tl) body.insert(body.size(), 8'($urandom));
        if (flags[2:1] != 2'b00) repeat (2) body.insert(body.size(), 8'($urandom));
        repeat (pl) body.insert(body.size(), 8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: cut = $urandom_range(0, 1);
            1: cut = (body.size() > 2) ? $urandom_range(2, body.size() - 1) : body.size();
            default: begin
              body[0] = 8'($urandom);
              cut = body.size();
            end
          endcase
          while (body.size() > cut) void'(body.pop_back());
        end
      end else if (sel < 55) begin
        hdr = {TYPE_CONNACK, flags};
        blen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 2;
        repeat (blen) body.insert(body.size(), 8'($urandom));
      end else if (sel < 70) begin
        hdr = {TYPE_SUBACK, flags};
        blen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 3;
        repeat (blen) body.insert(body.size(), 8'($urandom));
      end else if (sel < 90) begin
        do ptype = 4'($urandom);
        while (ptype == TYPE_CONNACK || ptype == TYPE_PUBLISH || ptype == TYPE_SUBACK);
        hdr = {ptype, flags};
        repeat ($urandom_range(0, 5)) body.insert(body.size(), 8'($urandom));
      end else begin
        // any header at all with an arbitrary body
        hdr = 8'($urandom);
        repeat ($urandom_range(0, 6)) body.insert(body.size(), 8'($urandom));
      end
      // remaining length, sometimes padded with extra continuation groups
      blen = body.size();
      minb = (blen < 128) ? 1 : (blen < 16384) ? 2 : 3;
      nb   = ($urandom_range(0, 7) == 0) ? $urandom_range(minb, MAX_LENGTH_BYTES) : minb;
      broker_bytes.insert(broker_bytes.size(), hdr);
      for (int k = 0; k < nb; k++)
        broker_bytes.insert(broker_bytes.size(),
                            {(k < nb - 1) ? 1'b1 : 1'b0, 7'(blen >> (7 * k))});
      foreach (body[i]) broker_bytes.insert(broker_bytes.size(), body[i]);
    end

    // overlong length closes the stream; the bytes after it must be dropped
    broker_bytes.insert(broker_bytes.size(), 8'($urandom));
    repeat (MAX_LENGTH_BYTES) broker_bytes.insert(broker_bytes.size(), 8'h80 | 8'($urandom));
    repeat (3) broker_bytes.insert(broker_bytes.size(), 8'($urandom));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (broker_bytes.size() != 0 || parsed_q.size() != 0) @(posedge clk);
    // let any stray result show up before closing
    repeat (40) @(posedge clk);

    $display("run: %0d broker bytes, %0d packet summaries (%0d malformed),",
             bytes_taken, n_summaries, n_malformed);
    $display("run: %0d topic and %0d payload bytes, ending on a halting overlong length",
             n_topic, n_payload);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mpd_pkg.sv
rtl/mpd_parser.sv
rtl/mpd_out_fifo.sv
rtl/mqtt_packet_deframer.sv
rtl/mpd_checker.sv
sim/tb.sv
